// ===== hw/rtl/udiv_pkg.sv =====
// Shared types and constants for the 64-by-32 restoring divider.
package udiv_pkg;

    localparam int DIVIDEND_BITS     = 64;
    localparam int DIVISOR_BITS      = 32;
    localparam int RESULT_BITS       = 32;
    localparam int DEFAULT_WORD_BITS = 32;

    typedef struct packed {
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } udiv_req_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] quotient;
        logic [RESULT_BITS-1:0] remainder;
    } udiv_rsp_t;

endpackage

// ===== hw/rtl/udiv_step.sv =====
// One registered compare-subtract step of the restoring divider pipeline.
module udiv_step
    import udiv_pkg::*;
#(
    parameter int WORD_BITS  = DEFAULT_WORD_BITS,
    parameter bit SHIFT_LEAD = 1'b1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] h_in,
    input  logic [WORD_BITS-1:0] l_in,
    input  logic [WORD_BITS-1:0] q_in,
    input  logic [WORD_BITS-1:0] v_in,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] h_out,
    output logic [WORD_BITS-1:0] l_out,
    output logic [WORD_BITS-1:0] q_out,
    output logic [WORD_BITS-1:0] v_out
);

    logic                 valid_reg;
    logic [WORD_BITS-1:0] h_reg, l_reg, q_reg, v_reg;
    logic [WORD_BITS-1:0] h_sh, l_sh, q_sh;
    logic                 c_sh;
    logic                 take;
    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] h_next, q_next;

    // Every step but the first begins with the shift left out of the previous step.
    // The bit that leaves the partial remainder forces the subtract.
    generate
        if (SHIFT_LEAD) begin : g_shift
            assign c_sh = h_in[WORD_BITS-1];
            assign h_sh = {h_in[WORD_BITS-2:0], l_in[WORD_BITS-1]};
            assign l_sh = {l_in[WORD_BITS-2:0], 1'b0};
            assign q_sh = {q_in[WORD_BITS-2:0], 1'b0};
        end else begin : g_noshift
            assign c_sh = 1'b0;
            assign h_sh = h_in;
            assign l_sh = l_in;
            assign q_sh = q_in;
        end
    endgenerate

    assign take   = c_sh | (h_sh >= v_in);
    assign diff   = h_sh - v_in;
    assign h_next = take ? diff : h_sh;
    assign q_next = {q_sh[WORD_BITS-1:1], q_sh[0] | take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            h_reg <= h_next;
            l_reg <= l_sh;
            q_reg <= q_next;
            v_reg <= v_in;
        end
    end

    assign out_valid = valid_reg;
    assign h_out     = h_reg;
    assign l_out     = l_reg;
    assign q_out     = q_reg;
    assign v_out     = v_reg;

endmodule

// ===== hw/rtl/unsigned_64_by_32_divider.sv =====
// Top level of the pipelined unsigned 64-by-32 restoring divider.
//
//  Channel | Ports                        | Direction | Payload
//  --------+------------------------------+-----------+----------------------------
//  input   | s_valid, s_ready, s_request  | in        | dividend[63:0], divisor[31:0]
//  result  | m_valid, m_ready, m_result   | out       | quotient[31:0], remainder[31:0]
//
// An accepted request passes one register stage for each compare-subtract step.
// A new request is taken every cycle while the result side keeps up.
// The whole pipeline advances together; it holds only while a result waits and
// m_ready is low, so a stall neither drops nor repeats a request.
// Synchronous active-low reset clears the valid bits; the data registers are not reset.
module unsigned_64_by_32_divider
    import udiv_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  udiv_req_t s_request,
    output logic      m_valid,
    input  logic      m_ready,
    output udiv_rsp_t m_result
);

    localparam int STEPS = WORD_BITS + 1;

    // Index 0 holds the unpacked request; index k+1 is the register after step k.
    logic                 valid_s [0:STEPS];
    logic [WORD_BITS-1:0] h_s     [0:STEPS];
    logic [WORD_BITS-1:0] l_s     [0:STEPS];
    logic [WORD_BITS-1:0] q_s     [0:STEPS];
    logic [WORD_BITS-1:0] v_s     [0:STEPS];
    logic                 advance;

    // The pipeline moves whenever the last stage is empty or is being drained.
    // This lets a new request in while a finished result is taken in the same cycle.
    assign advance = !valid_s[STEPS] || m_ready;
    assign s_ready = advance;

    // The high word seeds the partial remainder and the low word feeds its bottom bit,
    // one bit per step. Field bits above the word width are ignored.
    assign valid_s[0] = s_valid;
    assign h_s[0]     = s_request.dividend[2*WORD_BITS-1:WORD_BITS];
    assign l_s[0]     = s_request.dividend[WORD_BITS-1:0];
    assign q_s[0]     = '0;
    assign v_s[0]     = s_request.divisor[WORD_BITS-1:0];

    // The first step compares without a preceding shift; each later step shifts
    // the partial remainder, low word and quotient left, then compares and subtracts.
    // A zero divisor or an oversized high word simply runs the same sequence.
    generate
        for (genvar k = 0; k < STEPS; k++) begin : g_step
            udiv_step #(
                .WORD_BITS  (WORD_BITS),
                .SHIFT_LEAD (k != 0)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .in_valid  (valid_s[k]),
                .h_in      (h_s[k]),
                .l_in      (l_s[k]),
                .q_in      (q_s[k]),
                .v_in      (v_s[k]),
                .out_valid (valid_s[k+1]),
                .h_out     (h_s[k+1]),
                .l_out     (l_s[k+1]),
                .q_out     (q_s[k+1]),
                .v_out     (v_s[k+1])
            );
        end
    endgenerate

    // The last step's register is the output register; bits above the word are zero.
    assign m_valid            = valid_s[STEPS];
    assign m_result.quotient  = RESULT_BITS'(q_s[STEPS]);
    assign m_result.remainder = RESULT_BITS'(h_s[STEPS]);

endmodule

// ===== hw/rtl/udiv_checker.sv =====
// Port-level assertions for the divider, bound to its top level.
module udiv_port_checker
    import udiv_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input udiv_req_t s_request,
    input logic      m_valid,
    input logic      m_ready,
    input udiv_rsp_t m_result
);

    localparam int LATENCY  = WORD_BITS + 1;
    localparam int RUN_BITS = $clog2(LATENCY + 1);

    logic [RUN_BITS-1:0] ready_run_reg;
    logic [RUN_BITS-1:0] ready_run_next;

    // Counts consecutive cycles with m_ready high, saturating at the latency.
    always_comb begin
        if (!m_ready) begin
            ready_run_next = '0;
        end else if (ready_run_reg == RUN_BITS'(LATENCY)) begin
            ready_run_next = ready_run_reg;
        end else begin
            ready_run_next = ready_run_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_run_reg <= '0;
        end else begin
            ready_run_reg <= ready_run_next;
        end
    end

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed or vanished while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not track the output stage");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_valid && s_ready && aresetn, LATENCY)
            && (ready_run_reg >= RUN_BITS'(WORD_BITS)) |-> m_valid)
        else $error("accepted request did not arrive after the pipeline latency");

    // The request data is not inspected here.
    logic unused_request;
    assign unused_request = ^s_request;

endmodule

bind unsigned_64_by_32_divider udiv_port_checker #(.WORD_BITS(WORD_BITS)) u_udiv_checker (.*);
